### rtl/rbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpa_pkg
// Shared types and constants of the region bitmap page allocator: command
// codes, controller states, region bounds and address constants.
// ----------------------------------------------------------------------------
package rbpa_pkg;

    // Map geometry
    localparam int DEFAULT_NUM_PAGES = 4096;
    localparam int WORD_BITS         = 64;
    localparam int WORD_SHIFT        = 6;
    localparam int FRAME_SHIFT       = 12;
    localparam int MM_W              = 5;
    localparam int MM_SHIFT          = 8;

    // Fixed region bounds, in frames
    localparam int PAGING_LO  = 0;
    localparam int TASKS_LO   = 1280;
    localparam int STACK_LO   = 2304;
    localparam int KMALLOC_LO = 2560;
    localparam int GENERAL_LO = 2816;

    localparam logic [63:0]     KERNEL_VBASE = 64'hffff_ffff_8000_0000;
    localparam logic [MM_W-1:0] MM_RESET     = 5'd16;

    typedef enum logic [2:0] {
        CMD_INIT          = 3'd0,
        CMD_ALLOC_GENERAL = 3'd1,
        CMD_ALLOC_PAGING  = 3'd2,
        CMD_ALLOC_TASKS   = 3'd3,
        CMD_ALLOC_STACK   = 3'd4,
        CMD_ALLOC_KMALLOC = 3'd5,
        CMD_FREE          = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_FREE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

### rtl/rbpa_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpa_map_ram
// Free-bit map storage: one 64-bit word per 64 frames, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module rbpa_map_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/rbpa_bit_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpa_bit_find
// Lowest-set-bit finder for one 64-bit map word: isolates the lowest one
// with a two's complement trick and encodes its position.
// ----------------------------------------------------------------------------
module rbpa_bit_find (
    input  logic [63:0] word,
    output logic        hit,
    output logic [5:0]  idx,
    output logic [63:0] onehot
);

    import rbpa_pkg::*;

    // Isolate the lowest set bit
    assign onehot = word & (~word + 64'd1);
    assign hit    = |word;

    // Encode the one-hot position, one OR tree per index bit
    always_comb
    begin
        idx = '0;
        for (int k = 0; k < WORD_SHIFT; k++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (((j >> k) & 1) == 1)
                begin
                    idx[k] = idx[k] | onehot[j];
                end
            end
        end
    end

endmodule

### rtl/region_bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_bitmap_page_allocator
// First-fit page frame allocator over a free-bit map held in block memory.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one command per beat, command in s_tuser, frame byte
//   address (free only) in s_tdata. Master channel m_*: one result beat per
//   command, frame byte address in m_tdata, found and bad_free in m_tuser.
//   cfg_we/cfg_wdata write the installed memory size in MiB; write it only
//   while no command is in flight.
// Operation:
//   Allocate: after the command beat the region's 64-frame map words are
//   scanned in order until a free frame is found or the region ends, and
//   then the result beat is issued. Free: one read-modify-write, then the
//   result. Init: every 64-frame word below the page count is swept to all
//   free, then the result. One command at a time.
// Reset:
//   After rst_n is released the map is swept to all free, one word per
//   cycle, with s_tready low.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   command is still taken and its result is held until the register frees.
// ----------------------------------------------------------------------------
module region_bitmap_page_allocator #(
    parameter int NUM_PAGES = rbpa_pkg::DEFAULT_NUM_PAGES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Command stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // [23:0] page_address
    input  logic [2:0]                s_tuser,   // [2:0] command
    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,   // [63:0] frame_address
    output logic [1:0]                m_tuser,   // [0] found, [1] bad_free
    // Configuration
    input  logic                      cfg_we,
    input  logic [rbpa_pkg::MM_W-1:0] cfg_wdata
);

    import rbpa_pkg::*;

    localparam int NWORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = $clog2(NWORDS);
    localparam int WCW    = AW + 1;
    localparam int PC_W   = $clog2(NUM_PAGES + 1);
    localparam int PCW    = (PC_W > MM_W + MM_SHIFT) ? PC_W : MM_W + MM_SHIFT;

    state_t          state_reg, state_next;
    logic [MM_W-1:0] mm_reg;
    logic [WCW-1:0]  cnt_reg, cnt_next;
    logic [WCW-1:0]  end_reg, end_next;
    logic [WCW-1:0]  hi_word_reg, hi_word_next;
    logic [5:0]      hi_bits_reg, hi_bits_next;
    logic [5:0]      pn_bit_reg, pn_bit_next;
    logic            vbase_reg, vbase_next;
    logic            res_found_reg, res_found_next;
    logic [63:0]     res_fa_reg, res_fa_next;
    logic            res_bad_reg, res_bad_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [63:0]     m_tdata_reg, m_tdata_next;
    logic [1:0]      m_tuser_reg, m_tuser_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [63:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [63:0]     ram_rdata;

    logic            s_fire;
    logic            out_free;
    cmd_t            cmd;
    logic [11:0]     pn;
    logic            free_bad;
    logic [PCW-1:0]  pc_raw;
    logic [PCW-1:0]  pc;
    logic [WCW-1:0]  pc_end;
    logic [WCW-1:0]  dec_lo;
    logic [WCW-1:0]  dec_end;
    logic [WCW-1:0]  dec_hi_word;
    logic [5:0]      dec_hi_bits;
    logic            dec_vbase;
    logic            dec_alloc;
    logic [63:0]     scan_mask;
    logic [63:0]     scan_word;
    logic            find_hit;
    logic [5:0]      find_idx;
    logic [63:0]     find_onehot;
    logic [AW+5:0]   frame;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign pn       = s_tdata[23:FRAME_SHIFT];
    assign free_bad = PCW'(pn) >= PCW'(NUM_PAGES);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Page count from the configured size, capped at the map size
    assign pc_raw = PCW'({mm_reg, 8'h00});
    assign pc     = (pc_raw > PCW'(NUM_PAGES)) ? PCW'(NUM_PAGES) : pc_raw;
    assign pc_end = WCW'((PCW'(pc) + PCW'(WORD_BITS - 1)) >> WORD_SHIFT);

    // Decode the region of an allocate command into map words
    always_comb
    begin
        dec_lo      = '0;
        dec_end     = '0;
        dec_hi_word = '0;
        dec_hi_bits = '0;
        dec_vbase   = 1'b0;
        dec_alloc   = 1'b1;
        unique case (cmd)
            CMD_ALLOC_GENERAL:
            begin
                dec_lo      = WCW'(GENERAL_LO / WORD_BITS);
                dec_end     = pc_end;
                dec_hi_word = WCW'(pc >> WORD_SHIFT);
                dec_hi_bits = pc[5:0];
            end
            CMD_ALLOC_PAGING:
            begin
                dec_lo      = WCW'(PAGING_LO / WORD_BITS);
                dec_end     = WCW'(TASKS_LO / WORD_BITS);
                dec_hi_word = dec_end;
            end
            CMD_ALLOC_TASKS:
            begin
                dec_lo      = WCW'(TASKS_LO / WORD_BITS);
                dec_end     = WCW'(STACK_LO / WORD_BITS);
                dec_hi_word = dec_end;
            end
            CMD_ALLOC_STACK:
            begin
                dec_lo      = WCW'(STACK_LO / WORD_BITS);
                dec_end     = WCW'(KMALLOC_LO / WORD_BITS);
                dec_hi_word = dec_end;
                dec_vbase   = 1'b1;
            end
            CMD_ALLOC_KMALLOC:
            begin
                dec_lo      = WCW'(KMALLOC_LO / WORD_BITS);
                dec_end     = WCW'(GENERAL_LO / WORD_BITS);
                dec_hi_word = dec_end;
                dec_vbase   = 1'b1;
            end
            default:
            begin
                dec_alloc = 1'b0;
            end
        endcase
    end

    // Mask off frames past the region end in a partial last word
    always_comb
    begin
        if ((cnt_reg == hi_word_reg) && (hi_bits_reg != 6'd0))
        begin
            scan_mask = (64'd1 << hi_bits_reg) - 64'd1;
        end
        else
        begin
            scan_mask = '1;
        end
    end

    assign scan_word = ram_rdata & scan_mask;
    assign frame     = {cnt_reg[AW-1:0], find_idx};

    rbpa_bit_find u_find (
        .word   (scan_word),
        .hit    (find_hit),
        .idx    (find_idx),
        .onehot (find_onehot)
    );

    rbpa_map_ram #(
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == WCW'(NWORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (cmd == CMD_INIT)
                    begin
                        state_next = (pc_end == '0) ? ST_FINISH : ST_INIT;
                    end
                    else if (cmd == CMD_FREE)
                    begin
                        state_next = free_bad ? ST_FINISH : ST_FREE;
                    end
                    else if (dec_alloc)
                    begin
                        state_next = (dec_lo >= dec_end) ? ST_FINISH : ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_INIT:
            begin
                if (cnt_reg == end_reg - WCW'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FREE:
            begin
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (find_hit || (cnt_reg + WCW'(1) == end_reg))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and output register
    always_comb
    begin
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        hi_word_next   = hi_word_reg;
        hi_bits_next   = hi_bits_reg;
        pn_bit_next    = pn_bit_reg;
        vbase_next     = vbase_reg;
        res_found_next = res_found_reg;
        res_fa_next    = res_fa_reg;
        res_bad_next   = res_bad_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[AW-1:0];
        ram_wdata      = '1;
        ram_raddr      = AW'(cnt_reg + WCW'(1));
        unique case (state_reg) inside
            ST_CLEAR, ST_INIT:
            begin
                // Sweep words to all free
                ram_we   = 1'b1;
                cnt_next = cnt_reg + WCW'(1);
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    res_found_next = 1'b0;
                    res_fa_next    = '0;
                    res_bad_next   = 1'b0;
                    cnt_next       = '0;
                    end_next       = pc_end;
                    if (cmd == CMD_FREE)
                    begin
                        res_bad_next = free_bad;
                        cnt_next     = WCW'(pn[11:WORD_SHIFT]);
                        pn_bit_next  = pn[5:0];
                        ram_raddr    = AW'(pn[11:WORD_SHIFT]);
                    end
                    else if (dec_alloc)
                    begin
                        cnt_next     = dec_lo;
                        end_next     = dec_end;
                        hi_word_next = dec_hi_word;
                        hi_bits_next = dec_hi_bits;
                        vbase_next   = dec_vbase;
                        ram_raddr    = dec_lo[AW-1:0];
                    end
                end
            end
            ST_FREE:
            begin
                // Set the freed frame's bit in the word just read
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (64'd1 << pn_bit_reg);
            end
            ST_SCAN:
            begin
                if (find_hit)
                begin
                    // Claim the lowest free frame and write the word back
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata & ~find_onehot;
                    res_found_next = 1'b1;
                    res_fa_next    = (64'(frame) << FRAME_SHIFT)
                                     | (vbase_reg ? KERNEL_VBASE : 64'd0);
                end
                else
                begin
                    cnt_next = cnt_reg + WCW'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_fa_reg;
                    m_tuser_next  = {res_bad_reg, res_found_reg};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            mm_reg       <= MM_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                mm_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        end_reg       <= end_next;
        hi_word_reg   <= hi_word_next;
        hi_bits_reg   <= hi_bits_next;
        pn_bit_reg    <= pn_bit_next;
        vbase_reg     <= vbase_next;
        res_found_reg <= res_found_next;
        res_fa_reg    <= res_fa_next;
        res_bad_reg   <= res_bad_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule

### rtl/rbpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpa_checker
// Port-level checks of the page allocator result stream, bound to the top.
// ----------------------------------------------------------------------------
module rbpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Hold a stalled beat
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A beat is never both an allocation and a rejected free
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and bad_free both set");

    // No frame address without a found frame
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
        else $error("frame address set without found");

    // Allocated addresses are page aligned
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[11:0] == 12'd0)
        else $error("allocated address not page aligned");

endmodule

bind region_bitmap_page_allocator rbpa_checker u_rbpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
